@@ hdl/ghw_pkg.sv @@
`timescale 1ns / 1ps

package ghw_pkg;

    // Default geometry of the point store and the coordinate words
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    // Smallest set that is wrapped; smaller sets are echoed
    localparam int MIN_HULL_SET = 3;

endpackage

@@ hdl/ghw_ram.sv @@
`timescale 1ns / 1ps

module ghw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ghw_mul.sv @@
`timescale 1ns / 1ps

module ghw_mul #(
    parameter int OP_BITS = 17
) (
    input  logic                          i_clk,
    input  logic signed [OP_BITS-1:0]     i_a,
    input  logic signed [OP_BITS-1:0]     i_b,
    output logic signed [2*OP_BITS-1:0]   o_prod
);

    logic signed [2*OP_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

@@ hdl/convex_hull_gift_wrap.sv @@
`timescale 1ns / 1ps

// Channel   Valid     Ready     Word
// input     i_valid   o_ready   i_point_x, i_point_y, i_last_point
// output    o_valid   i_ready   o_hull_x, o_hull_y, o_last_of_hull, o_truncated
//
// Points load at one per cycle. On the last point the block goes busy: a small
// set is echoed point by point; otherwise a start search reads every point and
// each hull step sweeps all N points, each through a RAM read plus up to four
// products through the one shared multiplier. Results wait in an output
// register; a stalled output holds the walk. Reset is synchronous, active low.

module convex_hull_gift_wrap #(
    parameter int MAX_POINTS = ghw_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = ghw_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic                         i_last_point,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [COORD_BITS-1:0] o_hull_x,
    output logic signed [COORD_BITS-1:0] o_hull_y,
    output logic                         o_last_of_hull,
    output logic                         o_truncated
);

    import ghw_pkg::*;

    localparam int W     = COORD_BITS;
    localparam int D     = COORD_BITS + 1;
    localparam int P     = 2 * D;
    localparam int ACC_W = P + 1;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00_0000_0000_0001,
        S_ERD  = 14'b00_0000_0000_0010,
        S_ELD  = 14'b00_0000_0000_0100,
        S_SRD  = 14'b00_0000_0000_1000,
        S_SLD  = 14'b00_0000_0001_0000,
        S_WRD  = 14'b00_0000_0010_0000,
        S_WLD  = 14'b00_0000_0100_0000,
        S_M0   = 14'b00_0000_1000_0000,
        S_M1   = 14'b00_0001_0000_0000,
        S_M2   = 14'b00_0010_0000_0000,
        S_M3   = 14'b00_0100_0000_0000,
        S_M4   = 14'b00_1000_0000_0000,
        S_WEND = 14'b01_0000_0000_0000,
        S_FIN  = 14'b10_0000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_n, n_n;

    // start, current, best, pending and candidate points
    logic signed [W-1:0] r_sx, n_sx, r_sy, n_sy;
    logic signed [W-1:0] r_ux, n_ux, r_uy, n_uy;
    logic signed [W-1:0] r_bx, n_bx, r_by, n_by;
    logic signed [W-1:0] r_px, n_px, r_py, n_py;
    logic signed [W-1:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [ACC_W-1:0] r_acc, n_acc, r_dist, n_dist, r_bdist, n_bdist;

    logic                r_ovalid, n_ovalid;
    logic signed [W-1:0] r_ox, n_ox, r_oy, n_oy;
    logic                r_olast, n_olast, r_otrunc, n_otrunc;

    logic                w_accept;
    logic                w_out_free;
    logic                w_we;
    logic [2*W-1:0]      w_rdata;
    logic signed [W-1:0] w_rx, w_ry;
    logic                w_idx_last;
    logic [CNT_W-1:0]    w_cnt_after;
    logic                w_take;
    logic                w_same;
    logic signed [D-1:0] w_ma, w_mb;
    logic signed [P-1:0] w_prod;
    logic signed [ACC_W-1:0] w_sum, w_turn;

    ghw_ram #(
        .WIDTH (2 * W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[IDX_W-1:0]),
        .i_wdata ({i_point_y, i_point_x}),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    ghw_mul #(
        .OP_BITS (D)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    assign w_rx       = w_rdata[W-1:0];
    assign w_ry       = w_rdata[2*W-1:W];
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_we       = w_accept && (r_cnt < CNT_W'(MAX_POINTS));
    assign w_out_free = !r_ovalid || i_ready;
    assign w_idx_last = (CNT_W'(r_idx) + CNT_W'(1)) == r_cnt;
    assign w_cnt_after = w_we ? r_cnt + CNT_W'(1) : r_cnt;
    assign w_take     = (r_idx == '0) || (w_ry < r_sy) || ((w_ry == r_sy) && (w_rx < r_sx));
    assign w_same     = (w_rx == r_ux) && (w_ry == r_uy);
    assign w_sum      = r_acc + ACC_W'(w_prod);
    assign w_turn     = r_acc - ACC_W'(w_prod);

    // shared multiplier operands
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_M0: begin
                w_ma = D'(r_cx) - D'(r_ux);
                w_mb = D'(r_cx) - D'(r_ux);
            end
            S_M1: begin
                w_ma = D'(r_cy) - D'(r_uy);
                w_mb = D'(r_cy) - D'(r_uy);
            end
            S_M2: begin
                w_ma = D'(r_by) - D'(r_uy);
                w_mb = D'(r_cx) - D'(r_bx);
            end
            S_M3: begin
                w_ma = D'(r_bx) - D'(r_ux);
                w_mb = D'(r_cy) - D'(r_by);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_idx    = r_idx;
        n_n      = r_n;
        n_sx     = r_sx;
        n_sy     = r_sy;
        n_ux     = r_ux;
        n_uy     = r_uy;
        n_bx     = r_bx;
        n_by     = r_by;
        n_px     = r_px;
        n_py     = r_py;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_acc    = r_acc;
        n_dist   = r_dist;
        n_bdist  = r_bdist;
        n_ovalid = r_ovalid && !i_ready;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_olast  = r_olast;
        n_otrunc = r_otrunc;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cnt = w_cnt_after;
                    if (!w_we) begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_point) begin
                        n_idx = '0;
                        if (w_cnt_after < CNT_W'(MIN_HULL_SET)) begin
                            n_state = S_ERD;
                        end else begin
                            n_state = S_SRD;
                        end
                    end
                end
            end
            S_ERD: begin
                n_state = S_ELD;
            end
            S_ELD: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ox     = w_rx;
                    n_oy     = w_ry;
                    n_olast  = w_idx_last;
                    n_otrunc = r_ovf;
                    if (w_idx_last) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_ERD;
                    end
                end
            end
            S_SRD: begin
                n_state = S_SLD;
            end
            S_SLD: begin
                if (w_take) begin
                    n_sx = w_rx;
                    n_sy = w_ry;
                end
                if (w_idx_last) begin
                    // start point is the first pending result and the first pivot
                    n_ux    = w_take ? w_rx : r_sx;
                    n_uy    = w_take ? w_ry : r_sy;
                    n_px    = w_take ? w_rx : r_sx;
                    n_py    = w_take ? w_ry : r_sy;
                    n_n     = CNT_W'(1);
                    n_idx   = '0;
                    n_state = S_WRD;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_SRD;
                end
            end
            S_WRD: begin
                n_state = S_WLD;
            end
            S_WLD: begin
                n_cx = w_rx;
                n_cy = w_ry;
                if (r_idx == '0) begin
                    n_bx    = w_rx;
                    n_by    = w_ry;
                    n_bdist = '0;
                end
                if (w_same) begin
                    if (w_idx_last) begin
                        n_state = S_WEND;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_WRD;
                    end
                end else begin
                    n_state = S_M0;
                end
            end
            S_M0: begin
                n_state = S_M1;
            end
            S_M1: begin
                n_acc   = ACC_W'(w_prod);
                n_state = S_M2;
            end
            S_M2: begin
                n_dist = w_sum;
                if (r_idx == '0) begin
                    // first candidate only seeds the best distance
                    n_bdist = w_sum;
                    if (w_idx_last) begin
                        n_state = S_WEND;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_WRD;
                    end
                end else begin
                    n_state = S_M3;
                end
            end
            S_M3: begin
                n_acc   = ACC_W'(w_prod);
                n_state = S_M4;
            end
            S_M4: begin
                if (w_turn < 0 || (w_turn == 0 && r_dist > r_bdist)) begin
                    n_bx    = r_cx;
                    n_by    = r_cy;
                    n_bdist = r_dist;
                end
                if (w_idx_last) begin
                    n_state = S_WEND;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_WRD;
                end
            end
            S_WEND: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ox     = r_px;
                    n_oy     = r_py;
                    n_otrunc = r_ovf;
                    if (r_bx == r_sx && r_by == r_sy) begin
                        // wrapped back to the start: close the set
                        n_olast = 1'b1;
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_olast = 1'b0;
                        n_px    = r_bx;
                        n_py    = r_by;
                        n_ux    = r_bx;
                        n_uy    = r_by;
                        n_n     = r_n + CNT_W'(1);
                        n_idx   = '0;
                        if (r_n + CNT_W'(1) == r_cnt) begin
                            n_state = S_FIN;
                        end else begin
                            n_state = S_WRD;
                        end
                    end
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ox     = r_px;
                    n_oy     = r_py;
                    n_olast  = 1'b1;
                    n_otrunc = r_ovf;
                    n_cnt    = '0;
                    n_ovf    = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_n      <= n_n;
        r_sx     <= n_sx;
        r_sy     <= n_sy;
        r_ux     <= n_ux;
        r_uy     <= n_uy;
        r_bx     <= n_bx;
        r_by     <= n_by;
        r_px     <= n_px;
        r_py     <= n_py;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_acc    <= n_acc;
        r_dist   <= n_dist;
        r_bdist  <= n_bdist;
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_olast  <= n_olast;
        r_otrunc <= n_otrunc;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_hull_x       = r_ox;
    assign o_hull_y       = r_oy;
    assign o_last_of_hull = r_olast;
    assign o_truncated    = r_otrunc;

endmodule

@@ hdl/ghw_chk.sv @@
`timescale 1ns / 1ps

module ghw_chk #(
    parameter int COORD_BITS = ghw_pkg::COORD_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic signed [COORD_BITS-1:0] i_point_x,
    input logic signed [COORD_BITS-1:0] i_point_y,
    input logic                         i_last_point,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic signed [COORD_BITS-1:0] o_hull_x,
    input logic signed [COORD_BITS-1:0] o_hull_y,
    input logic                         o_last_of_hull,
    input logic                         o_truncated
);

    import ghw_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hull_x) && $stable(o_hull_y)
            && $stable(o_last_of_hull) && $stable(o_truncated))
        else $error("stalled result word changed");

    // no result word right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result word valid after reset");

    // closing point starts the walk: no new point taken next
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_last_point |=> !o_ready)
        else $error("input taken right after closing point");

    // a set stays busy until its final hull word is out
    a_busy_mid_hull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_hull |-> !o_ready)
        else $error("input ready while hull words remain");

endmodule

bind convex_hull_gift_wrap ghw_chk #(
    .COORD_BITS (COORD_BITS)
) u_ghw_chk (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_PTS = ghw_pkg::MAX_POINTS_DEF;
    localparam int CW      = ghw_pkg::COORD_BITS_DEF;

    // How random coordinates are drawn for one set
    localparam int STYLE_WIDE = 0;  // full 16-bit range
    localparam int STYLE_GRID = 1;  // tiny grid: duplicates and collinear runs
    localparam int STYLE_EDGE = 2;  // field extremes mixed with random values

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 last;
        logic                 trunc;
    } t_hull_pt;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic                 o_ready;
    logic signed [CW-1:0] i_point_x    = '0;
    logic signed [CW-1:0] i_point_y    = '0;
    logic                 i_last_point = 1'b0;
    logic                 o_valid;
    logic                 i_ready      = 1'b0;
    logic signed [CW-1:0] o_hull_x;
    logic signed [CW-1:0] o_hull_y;
    logic                 o_last_of_hull;
    logic                 o_truncated;

    // Point store mirror and expected hull words
    logic signed [CW-1:0] held_x [MAX_PTS];
    logic signed [CW-1:0] held_y [MAX_PTS];
    int                   held_count   = 0;
    logic                 held_dropped = 1'b0;
    t_hull_pt             hull_due [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;

    convex_hull_gift_wrap #(
        .MAX_POINTS(MAX_PTS),
        .COORD_BITS(CW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_last_point   (i_last_point),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hull_x       (o_hull_x),
        .o_hull_y       (o_hull_y),
        .o_last_of_hull (o_last_of_hull),
        .o_truncated    (o_truncated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic same_spot(int a, int b);
        return held_x[a] == held_x[b] && held_y[a] == held_y[b];
    endfunction

    // Negative when p -> q -> r turns counter-clockwise
    function automatic longint turn_of(int p, int q, int r);
        return (longint'(held_y[q]) - held_y[p]) * (longint'(held_x[r]) - held_x[q])
             - (longint'(held_x[q]) - held_x[p]) * (longint'(held_y[r]) - held_y[q]);
    endfunction

    function automatic longint span_sq(int a, int b);
        longint dx;
        longint dy;
        dx = longint'(held_x[a]) - held_x[b];
        dy = longint'(held_y[a]) - held_y[b];
        return dx * dx + dy * dy;
    endfunction

    // Store one accepted point; on the closing point queue the hull words
    function automatic void take_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                       logic last);
        int       order [$];
        int       start;
        int       cur;
        int       best;
        longint   t;
        t_hull_pt pt;
        if (held_count < MAX_PTS) begin
            held_x[held_count] = x;
            held_y[held_count] = y;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (!last) return;
        if (held_count < ghw_pkg::MIN_HULL_SET) begin
            for (int i = 0; i < held_count; i++) order = {order, i};
        end else begin
            start = 0;
            for (int i = 1; i < held_count; i++) begin
                if (held_y[i] < held_y[start] ||
                    (held_y[i] == held_y[start] && held_x[i] < held_x[start])) start = i;
            end
            order = {order, start};
            cur = start;
            while (order.size() < held_count) begin
                best = 0;
                for (int i = 0; i < held_count; i++) begin
                    if (!same_spot(i, cur)) begin
                        t = turn_of(cur, best, i);
                        if (t < 0 || (t == 0 && span_sq(cur, i) > span_sq(cur, best)))
                            best = i;
                    end
                end
                // back at the start: the hull is closed
                if (same_spot(best, start)) break;
                order = {order, best};
                cur = best;
            end
        end
        foreach (order[k]) begin
            pt.x     = held_x[order[k]];
            pt.y     = held_y[order[k]];
            pt.last  = (k == order.size() - 1);
            pt.trunc = held_dropped;
            hull_due = {hull_due, pt};
        end
        held_count   = 0;
        held_dropped = 1'b0;
    endfunction

    // Called just after a falling edge; returns just after a falling edge
    task automatic send_point(input int x, input int y, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_point_x    <= CW'(x);
        i_point_y    <= CW'(y);
        i_last_point <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        take_point(CW'(x), CW'(y), last);
        @(negedge i_clk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord(int style);
        case (style)
            STYLE_WIDE: return CW'($urandom);
            STYLE_GRID: return CW'($urandom_range(6) - 3);
            default: begin
                case ($urandom_range(4))
                    0: return {1'b1, {(CW-1){1'b0}}};
                    1: return {1'b0, {(CW-1){1'b1}}};
                    2: return '0;
                    3: return '1;
                    default: return CW'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic send_random_set(int size, int style);
        for (int i = 0; i < size; i++)
            send_point(int'(rand_coord(style)), int'(rand_coord(style)), i == size - 1);
    endtask

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_hull_pt want;
        if (i_rst_n && o_valid && i_ready) begin
            if (hull_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected hull word: x=%0d y=%0d last=%0b trunc=%0b",
                             o_hull_x, o_hull_y, o_last_of_hull, o_truncated);
            end else begin
                want = hull_due.pop_front();
                if (o_hull_x !== want.x || o_hull_y !== want.y ||
                    o_last_of_hull !== want.last || o_truncated !== want.trunc) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("hull word: expected x=%0d y=%0d last=%0b trunc=%0b, %s",
                                 $signed(want.x), $signed(want.y), want.last, want.trunc,
                                 $sformatf("got x=%0d y=%0d last=%0b trunc=%0b",
                                           o_hull_x, o_hull_y, o_last_of_hull,
                                           o_truncated));
                end
            end
        end
    end

    // Sets of one and two points come back as sent
    task automatic test_echo_sets();
        send_point(-32768, 32767, 1'b1);
        send_point(32767, -32768, 1'b0);
        send_point(-1, 0, 1'b1);
    endtask

    // Coincident, collinear and duplicated points
    task automatic test_degenerate_sets();
        send_point(5, 5, 1'b0);
        send_point(5, 5, 1'b0);
        send_point(5, 5, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(10, 10, 1'b0);
        send_point(5, 5, 1'b0);
        send_point(-3, -3, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(100, 0, 1'b0);
        send_point(0, 0, 1'b0);
        send_point(100, 100, 1'b0);
        send_point(0, 100, 1'b0);
        send_point(100, 100, 1'b1);
    endtask

    // Corners of the coordinate range, lowest row tied
    task automatic test_extreme_corners();
        send_point(32767, -32768, 1'b0);
        send_point(-32768, -32768, 1'b0);
        send_point(32767, 32767, 1'b0);
        send_point(-32768, 32767, 1'b0);
        send_point(0, 0, 1'b1);
    endtask

    // Full store, every point on the hull (points on a parabola, shuffled)
    task automatic test_full_convex_set();
        int ks [MAX_PTS];
        int j;
        int tmp;
        for (int i = 0; i < MAX_PTS; i++) ks[i] = i - MAX_PTS / 2;
        for (int i = MAX_PTS - 1; i > 0; i--) begin
            j      = $urandom_range(i);
            tmp    = ks[i];
            ks[i]  = ks[j];
            ks[j]  = tmp;
        end
        for (int i = 0; i < MAX_PTS; i++)
            send_point(ks[i] * 1000, ks[i] * ks[i] * 30, i == MAX_PTS - 1);
    endtask

    // Points past capacity, closing point dropped too
    task automatic test_overflow_sets();
        send_random_set(MAX_PTS + 2, STYLE_WIDE);
        send_random_set(MAX_PTS + 5, STYLE_GRID);
    endtask

    task automatic run_random_phase(int send_pct, int recv_pct);
        int sent;
        int size;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < 56) begin
            size = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            send_random_set(size, $urandom_range(STYLE_EDGE));
            sent += size;
        end
    endtask

    task automatic test_random_sets();
        run_random_phase(0, 0);
        run_random_phase(55, 0);
        run_random_phase(0, 55);
        run_random_phase(17, 17);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_echo_sets();
        test_degenerate_sets();
        test_extreme_corners();
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        test_full_convex_set();
        test_overflow_sets();
        test_random_sets();
        i_valid <= 1'b0;
        while (hull_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && hull_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/ghw_pkg.sv
hdl/ghw_ram.sv
hdl/ghw_mul.sv
hdl/convex_hull_gift_wrap.sv
hdl/ghw_chk.sv
verif/tb_top.sv
